// File: rtl/smnh_pkg.sv
// shared types and constants of the stacked memory next-hop router
package smnh_pkg;

  localparam int unsigned DEST_W     = 11;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned LAYER_W    = 3;
  localparam int unsigned BANK_W     = 4;
  localparam int unsigned SUB_W      = 4;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  typedef enum logic [MODE_W-1:0] {
    TOPO_RING,
    TOPO_SEMI_RING,
    TOPO_CROSSBAR,
    TOPO_IDEAL
  } topo_e;

  typedef enum logic [KIND_W-1:0] {
    HOP_ARRIVED,
    HOP_SUB_UP,
    HOP_SUB_DOWN,
    HOP_NEXT_BANK,
    HOP_LAYER_UP,
    HOP_LAYER_DOWN,
    HOP_JUMP
  } hop_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOPOLOGY_MODE,
    CFG_OWN_LAYER,
    CFG_OWN_BANK,
    CFG_OWN_SUBARRAY
  } cfg_reg_e;

  typedef struct packed {
    topo_e              mode;
    logic [LAYER_W-1:0] own_layer;
    logic [BANK_W-1:0]  own_bank;
    logic [SUB_W-1:0]   own_subarray;
  } cfg_t;

  typedef struct packed {
    hop_kind_e          kind;
    logic [LAYER_W-1:0] next_layer;
    logic [BANK_W-1:0]  next_bank;
    logic [SUB_W-1:0]   next_subarray;
  } hop_t;

endpackage

// File: rtl/smnh_route.sv
// next-hop decision: destination decode and per-topology routing
module smnh_route import smnh_pkg::*; #(
  parameter int unsigned SUBARRAYS_PER_BANK = 16,
  parameter int unsigned BANKS_PER_LAYER    = 16,
  parameter int unsigned LAYERS             = 8
) (
  input  cfg_t              cfg_i,
  input  logic [DEST_W-1:0] dest_i,
  output hop_t              hop_o
);

  localparam int unsigned LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int unsigned BW = $clog2(BANKS_PER_LAYER);
  localparam int unsigned SW = $clog2(SUBARRAYS_PER_BANK);

  // reciprocal constants, exact for every DEST_W-bit dividend
  localparam int unsigned MW = DEST_W + 2;
  localparam int unsigned PW = DEST_W + MW;
  localparam int unsigned K1 = DEST_W + $clog2(SUBARRAYS_PER_BANK);
  localparam int unsigned K2 = DEST_W + $clog2(BANKS_PER_LAYER);
  localparam int unsigned M1 = ((32'd1 << K1) / SUBARRAYS_PER_BANK) + 1;
  localparam int unsigned M2 = ((32'd1 << K2) / BANKS_PER_LAYER) + 1;

  localparam logic [DEST_W-1:0] L_MAX = DEST_W'(LAYERS - 1);
  localparam logic [DEST_W-1:0] B_MAX = DEST_W'(BANKS_PER_LAYER - 1);
  localparam logic [DEST_W-1:0] S_MAX = DEST_W'(SUBARRAYS_PER_BANK - 1);
  localparam logic [DEST_W-1:0] B_NUM = DEST_W'(BANKS_PER_LAYER);

  logic [PW-1:0]     prod1, prod2, back1, back2;
  logic [DEST_W-1:0] q1, q2;
  logic [LW-1:0]     dl;
  logic [BW-1:0]     db;
  logic [SW-1:0]     ds;
  logic [DEST_W-1:0] dl_x, db_x, ds_x;
  logic [DEST_W-1:0] ol_x, ob_x, os_x;
  logic [LAYER_W-1:0] ol, ol_up, ol_dn;
  logic [BANK_W-1:0]  ob, nb;
  logic [BANK_W:0]    ob_inc;
  logic [SUB_W-1:0]   os, os_up, os_dn;
  logic same_layer, layer_lt, layer_gt, bank_eq, same_bank;
  logic os_zero, os_top, os_lt_ds, os_gt_ds, arrived;
  hop_t hop;

  // destination decode: subarray, bank and layer digits
  assign prod1 = PW'(dest_i) * PW'(MW'(M1));
  assign q1    = DEST_W'(prod1 >> K1);
  assign back1 = PW'(q1) * PW'(SUBARRAYS_PER_BANK);
  assign ds    = SW'(dest_i - back1[DEST_W-1:0]);

  assign prod2 = PW'(q1) * PW'(MW'(M2));
  assign q2    = DEST_W'(prod2 >> K2);
  assign back2 = PW'(q2) * PW'(BANKS_PER_LAYER);
  assign db    = BW'(q1 - back2[DEST_W-1:0]);
  assign dl    = (q2 > L_MAX) ? LW'(L_MAX) : LW'(q2);

  assign dl_x = DEST_W'(dl);
  assign db_x = DEST_W'(db);
  assign ds_x = DEST_W'(ds);

  // own coordinates clamp to the stack size
  assign ol_x = (DEST_W'(cfg_i.own_layer) > L_MAX) ? L_MAX : DEST_W'(cfg_i.own_layer);
  assign ob_x = (DEST_W'(cfg_i.own_bank) > B_MAX) ? B_MAX : DEST_W'(cfg_i.own_bank);
  assign os_x = (DEST_W'(cfg_i.own_subarray) > S_MAX) ? S_MAX : DEST_W'(cfg_i.own_subarray);
  assign ol   = ol_x[LAYER_W-1:0];
  assign ob   = ob_x[BANK_W-1:0];
  assign os   = os_x[SUB_W-1:0];

  assign ol_up  = ol + LAYER_W'(1);
  assign ol_dn  = ol - LAYER_W'(1);
  assign os_up  = os + SUB_W'(1);
  assign os_dn  = os - SUB_W'(1);
  assign ob_inc = {1'b0, ob} + (BANK_W + 1)'(1);
  assign nb     = (DEST_W'(ob_inc) == B_NUM) ? '0 : ob_inc[BANK_W-1:0];

  assign same_layer = (ol_x == dl_x);
  assign layer_lt   = (ol_x < dl_x);
  assign layer_gt   = (ol_x > dl_x);
  assign bank_eq    = (ob_x == db_x);
  assign same_bank  = same_layer && bank_eq;
  assign os_zero    = (os_x == '0);
  assign os_top     = (os_x == S_MAX);
  assign os_lt_ds   = (os_x < ds_x);
  assign os_gt_ds   = (os_x > ds_x);
  assign arrived    = same_bank && (os_x == ds_x);

  always_comb begin
    hop = '{kind: HOP_ARRIVED, next_layer: ol, next_bank: ob, next_subarray: os};
    if (!arrived) begin
      case (cfg_i.mode)
        TOPO_RING: begin
          if (os_zero && !same_layer) begin
            if (layer_lt) begin
              hop = '{kind: HOP_LAYER_UP, next_layer: ol_up, next_bank: ob, next_subarray: '0};
            end else begin
              hop = '{kind: HOP_LAYER_DOWN, next_layer: ol_dn, next_bank: ob, next_subarray: '0};
            end
          end else if (!ob[0]) begin
            // even bank climbs, then crosses at the top subarray
            if (!os_top) begin
              hop = '{kind: HOP_SUB_UP, next_layer: ol, next_bank: ob, next_subarray: os_up};
            end else begin
              hop = '{kind: HOP_NEXT_BANK, next_layer: ol, next_bank: nb,
                      next_subarray: S_MAX[SUB_W-1:0]};
            end
          end else if (!os_zero) begin
            hop = '{kind: HOP_SUB_DOWN, next_layer: ol, next_bank: ob, next_subarray: os_dn};
          end else begin
            hop = '{kind: HOP_NEXT_BANK, next_layer: ol, next_bank: nb, next_subarray: '0};
          end
        end
        TOPO_SEMI_RING: begin
          if (os_zero && !bank_eq) begin
            hop = '{kind: HOP_NEXT_BANK, next_layer: ol, next_bank: nb, next_subarray: '0};
          end else if (os_zero && layer_lt) begin
            hop = '{kind: HOP_LAYER_UP, next_layer: ol_up, next_bank: ob, next_subarray: '0};
          end else if (os_zero && layer_gt) begin
            hop = '{kind: HOP_LAYER_DOWN, next_layer: ol_dn, next_bank: ob, next_subarray: '0};
          end else if (same_bank && os_lt_ds) begin
            hop = '{kind: HOP_SUB_UP, next_layer: ol, next_bank: ob, next_subarray: os_up};
          end else begin
            hop = '{kind: HOP_SUB_DOWN, next_layer: ol, next_bank: ob, next_subarray: os_dn};
          end
        end
        TOPO_CROSSBAR: begin
          if (same_bank) begin
            if (os_gt_ds) begin
              hop = '{kind: HOP_SUB_DOWN, next_layer: ol, next_bank: ob, next_subarray: os_dn};
            end else begin
              hop = '{kind: HOP_SUB_UP, next_layer: ol, next_bank: ob, next_subarray: os_up};
            end
          end else if (!os_zero) begin
            hop = '{kind: HOP_SUB_DOWN, next_layer: ol, next_bank: ob, next_subarray: os_dn};
          end else if (!bank_eq) begin
            // wrong bank: sink to layer 0, where the crossbar spans all banks
            if (ol_x == '0) begin
              hop = '{kind: HOP_JUMP, next_layer: '0, next_bank: db_x[BANK_W-1:0],
                      next_subarray: '0};
            end else begin
              hop = '{kind: HOP_LAYER_DOWN, next_layer: ol_dn, next_bank: ob, next_subarray: '0};
            end
          end else if (layer_lt) begin
            hop = '{kind: HOP_LAYER_UP, next_layer: ol_up, next_bank: ob, next_subarray: '0};
          end else begin
            hop = '{kind: HOP_LAYER_DOWN, next_layer: ol_dn, next_bank: ob, next_subarray: '0};
          end
        end
        TOPO_IDEAL: begin
          hop = '{kind: HOP_JUMP, next_layer: dl_x[LAYER_W-1:0],
                  next_bank: db_x[BANK_W-1:0], next_subarray: ds_x[SUB_W-1:0]};
        end
        default: begin
          hop = '{kind: HOP_JUMP, next_layer: dl_x[LAYER_W-1:0],
                  next_bank: db_x[BANK_W-1:0], next_subarray: ds_x[SUB_W-1:0]};
        end
      endcase
    end
  end

  assign hop_o = hop;

endmodule

// File: rtl/stacked_memory_next_hop_router.sv
// Next-hop router of one stacked memory node. Each destination index taken on the
// input channel yields exactly one result: the hop kind and the layer, bank and
// subarray of the neighbor to move to, or an arrived flag with the node's own
// coordinates. The block takes one transaction per cycle unless a held result backs
// up the input; each passes through the input register, then the routing logic into
// the result register. While a result waits, the input register may take one more.
// Topology mode and own coordinates are set through the configuration port, which
// is always ready; write it only while no transaction is in flight.
module stacked_memory_next_hop_router import smnh_pkg::*; #(
  parameter int unsigned SUBARRAYS_PER_BANK = 16,
  parameter int unsigned BANKS_PER_LAYER    = 16,
  parameter int unsigned LAYERS             = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DEST_W-1:0]     dest_index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KIND_W-1:0]     hop_kind_o,
  output logic [LAYER_W-1:0]    next_layer_o,
  output logic [BANK_W-1:0]     next_bank_o,
  output logic [SUB_W-1:0]      next_subarray_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t              cfg_q;
  logic              in_valid_q, out_valid_q;
  logic [DEST_W-1:0] dest_q;
  hop_t              hop_d, hop_q;
  logic              s1_ready, s2_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: TOPO_RING, own_layer: '0, own_bank: '0, own_subarray: '0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TOPOLOGY_MODE: cfg_q.mode         <= topo_e'(cfg_data_i[MODE_W-1:0]);
        CFG_OWN_LAYER:     cfg_q.own_layer    <= cfg_data_i[LAYER_W-1:0];
        CFG_OWN_BANK:      cfg_q.own_bank     <= cfg_data_i[BANK_W-1:0];
        CFG_OWN_SUBARRAY:  cfg_q.own_subarray <= cfg_data_i[SUB_W-1:0];
        default: ;
      endcase
    end
  end

  // two-stage pipeline, each stage moves when the one after it has room
  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_ready   = !in_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      dest_q <= dest_index_i;
    end
    if (s2_ready && in_valid_q) begin
      hop_q <= hop_d;
    end
  end

  smnh_route #(
    .SUBARRAYS_PER_BANK(SUBARRAYS_PER_BANK),
    .BANKS_PER_LAYER   (BANKS_PER_LAYER),
    .LAYERS            (LAYERS)
  ) u_route (
    .cfg_i  (cfg_q),
    .dest_i (dest_q),
    .hop_o  (hop_d)
  );

  assign out_valid_o     = out_valid_q;
  assign hop_kind_o      = hop_q.kind;
  assign next_layer_o    = hop_q.next_layer;
  assign next_bank_o     = hop_q.next_bank;
  assign next_subarray_o = hop_q.next_subarray;

endmodule

// File: rtl/smnh_checker.sv
// port-level checks of the next-hop router and their binding
module smnh_checker import smnh_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [KIND_W-1:0]     hop_kind_o,
  input logic [LAYER_W-1:0]    next_layer_o,
  input logic [BANK_W-1:0]     next_bank_o,
  input logic [SUB_W-1:0]      next_subarray_o
);

  // input side only backs up when a result is held on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // an accepted transaction reaches the output unless a held result blocks the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted transaction did not reach the output");

  // a result appearing on an empty output matches an earlier accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching transaction");

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(hop_kind_o)
      && $stable(next_layer_o) && $stable(next_bank_o) && $stable(next_subarray_o)))
    else $error("stalled result changed");

endmodule

bind stacked_memory_next_hop_router smnh_checker u_smnh_checker (.*);

// File: verif/testbench.sv
// testbench of the stacked memory next-hop router: routing predictor, driver, monitor
`timescale 1ns / 100ps

module testbench;
  import smnh_pkg::*;

  localparam int unsigned SUBARRAYS_PER_BANK = 16;
  localparam int unsigned BANKS_PER_LAYER    = 16;
  localparam int unsigned LAYERS             = 8;
  localparam int unsigned STALL_LIMIT        = 1000;
  localparam int unsigned RANDOM_PER_SETTING = 117;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [DEST_W-1:0]     dest_index_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [KIND_W-1:0]     hop_kind_o;
  logic [LAYER_W-1:0]    next_layer_o;
  logic [BANK_W-1:0]     next_bank_o;
  logic [SUB_W-1:0]      next_subarray_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // node settings as the router should hold them
  topo_e              cur_mode = TOPO_RING;
  logic [LAYER_W-1:0] cur_layer = '0;
  logic [BANK_W-1:0]  cur_bank = '0;
  logic [SUB_W-1:0]   cur_sub = '0;

  logic [DEST_W-1:0] dest_backlog[$];
  hop_t              hop_due[$];

  bit          in_fire, out_fire, cfg_fire;
  hop_t        want;
  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;
  int unsigned in_taken;
  int unsigned next_hold_at = 150;
  int unsigned hold_left;
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 49;

  stacked_memory_next_hop_router #(
    .SUBARRAYS_PER_BANK(SUBARRAYS_PER_BANK),
    .BANKS_PER_LAYER   (BANKS_PER_LAYER),
    .LAYERS            (LAYERS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .dest_index_i   (dest_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hop_kind_o     (hop_kind_o),
    .next_layer_o   (next_layer_o),
    .next_bank_o    (next_bank_o),
    .next_subarray_o(next_subarray_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned clip(int unsigned v, int unsigned maxv);
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic hop_t make_hop(hop_kind_e k, int unsigned l, int unsigned b,
                                    int unsigned s);
    hop_t h;
    h.kind          = k;
    h.next_layer    = LAYER_W'(l);
    h.next_bank     = BANK_W'(b);
    h.next_subarray = SUB_W'(s);
    return h;
  endfunction

  function automatic hop_t route_hop(logic [DEST_W-1:0] dest);
    int unsigned ol, ob, os, dl, db, ds, nb;
    bit          same_bank;
    ol = clip(cur_layer, LAYERS - 1);
    ob = clip(cur_bank, BANKS_PER_LAYER - 1);
    os = clip(cur_sub, SUBARRAYS_PER_BANK - 1);
    dl = clip(dest / (SUBARRAYS_PER_BANK * BANKS_PER_LAYER), LAYERS - 1);
    db = (dest / SUBARRAYS_PER_BANK) % BANKS_PER_LAYER;
    ds = dest % SUBARRAYS_PER_BANK;
    nb = (ob + 1) % BANKS_PER_LAYER;
    same_bank = (ol == dl) && (ob == db);

    if (same_bank && os == ds) return make_hop(HOP_ARRIVED, ol, ob, os);

    case (cur_mode)
      TOPO_RING: begin
        if (os == 0 && ol != dl) begin
          if (ol < dl) return make_hop(HOP_LAYER_UP, ol + 1, ob, 0);
          return make_hop(HOP_LAYER_DOWN, ol - 1, ob, 0);
        end
        // snake: even banks climb, odd banks descend
        if (ob % 2 == 0) begin
          if (os != SUBARRAYS_PER_BANK - 1) return make_hop(HOP_SUB_UP, ol, ob, os + 1);
          return make_hop(HOP_NEXT_BANK, ol, nb, SUBARRAYS_PER_BANK - 1);
        end
        if (os != 0) return make_hop(HOP_SUB_DOWN, ol, ob, os - 1);
        return make_hop(HOP_NEXT_BANK, ol, nb, 0);
      end
      TOPO_SEMI_RING: begin
        if (os == 0) begin
          if (ob != db) return make_hop(HOP_NEXT_BANK, ol, nb, 0);
          if (ol < dl) return make_hop(HOP_LAYER_UP, ol + 1, ob, 0);
          if (ol > dl) return make_hop(HOP_LAYER_DOWN, ol - 1, ob, 0);
        end
        if (same_bank && os < ds) return make_hop(HOP_SUB_UP, ol, ob, os + 1);
        return make_hop(HOP_SUB_DOWN, ol, ob, os - 1);
      end
      TOPO_CROSSBAR: begin
        if (same_bank) begin
          if (os > ds) return make_hop(HOP_SUB_DOWN, ol, ob, os - 1);
          return make_hop(HOP_SUB_UP, ol, ob, os + 1);
        end
        if (os != 0) return make_hop(HOP_SUB_DOWN, ol, ob, os - 1);
        if (ob != db) begin
          if (ol == 0) return make_hop(HOP_JUMP, 0, db, 0);
          return make_hop(HOP_LAYER_DOWN, ol - 1, ob, 0);
        end
        if (ol < dl) return make_hop(HOP_LAYER_UP, ol + 1, ob, 0);
        return make_hop(HOP_LAYER_DOWN, ol - 1, ob, 0);
      end
      default: return make_hop(HOP_JUMP, dl, db, ds);
    endcase
  endfunction

  function automatic logic [DEST_W-1:0] pick_dest();
    int unsigned r;
    int unsigned own_idx;
    r = $urandom_range(99);
    own_idx = (cur_layer * BANKS_PER_LAYER + cur_bank) * SUBARRAYS_PER_BANK + cur_sub;
    if (r < 35) return DEST_W'($urandom);
    if (r < 65)
      return DEST_W'((cur_layer * BANKS_PER_LAYER + cur_bank) * SUBARRAYS_PER_BANK
                     + $urandom_range(SUBARRAYS_PER_BANK - 1));
    if (r < 85)
      return DEST_W'(cur_layer * BANKS_PER_LAYER * SUBARRAYS_PER_BANK
                     + $urandom_range(BANKS_PER_LAYER * SUBARRAYS_PER_BANK - 1));
    if (r < 90) return '0;
    if (r < 95) return '1;
    return DEST_W'(own_idx);
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatch_cnt++;
    end
  endtask

  // wait until every offered item is taken and every result is back
  task automatic drain();
    while (dest_backlog.size() != 0 || hop_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TOPOLOGY_MODE: cur_mode  = topo_e'(data[MODE_W-1:0]);
      CFG_OWN_LAYER:     cur_layer = data[LAYER_W-1:0];
      CFG_OWN_BANK:      cur_bank  = data[BANK_W-1:0];
      CFG_OWN_SUBARRAY:  cur_sub   = data[SUB_W-1:0];
      default: ;
    endcase
  endtask

  // upper data bits of the narrow registers are random junk the router must drop
  task automatic configure(topo_e m, int unsigned l, int unsigned b, int unsigned s);
    drain();
    cfg_write(CFG_TOPOLOGY_MODE, {2'($urandom_range(3)), m});
    cfg_write(CFG_OWN_LAYER, {1'($urandom_range(1)), LAYER_W'(l)});
    cfg_write(CFG_OWN_BANK, BANK_W'(b));
    cfg_write(CFG_OWN_SUBARRAY, SUB_W'(s));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic probe(topo_e m, int unsigned l, int unsigned b, int unsigned s,
                       int unsigned dest);
    configure(m, l, b, s);
    dest_backlog.push_back(DEST_W'(dest));
  endtask

  // input driver: holds a stalled transaction, otherwise offers the next one at random
  always @(negedge clk_i) begin
    if (in_valid_i && !in_fire) begin
      in_valid_i <= 1'b1;
    end else if (dest_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid_i   <= 1'b1;
      dest_index_i <= dest_backlog[0];
    end else begin
      in_valid_i   <= 1'b0;
      dest_index_i <= DEST_W'($urandom);
    end
  end

  // result side backpressure, with an occasional long hold-off to fill the pipe
  always @(negedge clk_i) begin
    if (hold_left == 0 && in_taken >= next_hold_at) begin
      hold_left    = 60;
      next_hold_at = next_hold_at + 400;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    cfg_fire = rst_ni && cfg_valid_i && cfg_ready_o;

    if (in_fire) begin
      hop_due.push_back(route_hop(dest_index_i));
      void'(dest_backlog.pop_front());
      in_taken++;
    end

    if (out_fire) begin
      if (hop_due.size() == 0) begin
        $error("result with nothing pending: hop_kind %0d", hop_kind_o);
        mismatch_cnt++;
      end else begin
        want = hop_due.pop_front();
        check_field("hop_kind", want.kind, hop_kind_o);
        check_field("next_layer", want.next_layer, next_layer_o);
        check_field("next_bank", want.next_bank, next_bank_o);
        check_field("next_subarray", want.next_subarray, next_subarray_o);
      end
    end

    if (in_fire || out_fire || cfg_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    topo_e       m;
    int unsigned l, b, s;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ring
    probe(TOPO_RING, 0, 0, 0, 0);
    probe(TOPO_RING, 0, 0, 0, 2047);
    probe(TOPO_RING, 0, 0, 0, 1);
    probe(TOPO_RING, 7, 3, 0, 0);
    probe(TOPO_RING, 2, 4, 5, 512);
    probe(TOPO_RING, 2, 4, 15, 512);
    probe(TOPO_RING, 2, 5, 5, 512);
    probe(TOPO_RING, 2, 15, 0, 512);
    // semi-ring
    probe(TOPO_SEMI_RING, 3, 2, 0, (3 * 16 + 7) * 16 + 4);
    probe(TOPO_SEMI_RING, 3, 7, 0, (5 * 16 + 7) * 16);
    probe(TOPO_SEMI_RING, 5, 7, 0, (3 * 16 + 7) * 16 + 1);
    probe(TOPO_SEMI_RING, 3, 7, 2, (3 * 16 + 7) * 16 + 9);
    probe(TOPO_SEMI_RING, 3, 7, 9, (3 * 16 + 7) * 16 + 2);
    probe(TOPO_SEMI_RING, 3, 2, 6, 2047);
    // crossbar, including the jump from layer 0
    probe(TOPO_CROSSBAR, 4, 6, 3, (4 * 16 + 6) * 16 + 10);
    probe(TOPO_CROSSBAR, 4, 6, 12, (4 * 16 + 6) * 16 + 10);
    probe(TOPO_CROSSBAR, 4, 6, 12, 0);
    probe(TOPO_CROSSBAR, 0, 6, 0, (7 * 16 + 9) * 16 + 3);
    probe(TOPO_CROSSBAR, 4, 6, 0, (7 * 16 + 9) * 16);
    probe(TOPO_CROSSBAR, 4, 6, 0, (7 * 16 + 6) * 16 + 5);
    probe(TOPO_CROSSBAR, 7, 6, 0, 6 * 16);
    // ideal direct
    probe(TOPO_IDEAL, 7, 15, 15, 2047);
    probe(TOPO_IDEAL, 7, 15, 15, 0);
    probe(TOPO_IDEAL, 0, 0, 0, 1365);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 31; recv_idle_pct = 49; end
        1: begin send_idle_pct = 49; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int k = 0; k < 4; k++) begin
        m = topo_e'((k + ph) % 4);
        if (k == 0) begin
          l = 0; b = 0; s = 0;
        end else if (k == 3) begin
          l = LAYERS - 1; b = BANKS_PER_LAYER - 1; s = SUBARRAYS_PER_BANK - 1;
        end else begin
          l = $urandom_range(LAYERS - 1);
          b = $urandom_range(BANKS_PER_LAYER - 1);
          s = $urandom_range(SUBARRAYS_PER_BANK - 1);
        end
        configure(m, l, b, s);
        repeat (RANDOM_PER_SETTING) dest_backlog.push_back(pick_dest());
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/smnh_pkg.sv
rtl/smnh_route.sv
rtl/stacked_memory_next_hop_router.sv
rtl/smnh_checker.sv
verif/testbench.sv
